FILE: hdl/saw_pkg.sv
// Shared types and constants for the stop-and-wait frame sender.
package saw_pkg;

  // Header flag bit positions
  localparam int unsigned FlagAckBit = 4;
  localparam int unsigned FlagExtBit = 5;

  // Checksum word width and saturation limit of the tick counter
  localparam int unsigned WordW = 16;
  localparam logic [WordW-1:0] WordOnes = '1;

  // Configuration register indexes
  localparam logic CfgTimeoutTicks = 1'b0;
  localparam logic CfgMaxRetries   = 1'b1;

  // Configuration reset values
  localparam logic [15:0] TimeoutTicksRst = 16'd50;
  localparam logic [3:0]  MaxRetriesRst   = 4'd10;

  typedef enum logic [1:0] {
    CMD_SEND = 2'd0,
    CMD_TICK = 2'd1,
    CMD_RECV = 2'd2
  } saw_cmd_e;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_SENT       = 3'd1,
    ST_REJECTED   = 3'd2,
    ST_RETRANSMIT = 3'd3,
    ST_GAVE_UP    = 3'd4,
    ST_ACKED      = 3'd5,
    ST_IGNORED    = 3'd6
  } saw_status_e;

  // One result item as held in the output register
  typedef struct packed {
    logic [2:0]  status;
    logic        tx_valid;
    logic [31:0] tx_flags;
    logic [15:0] tx_seq;
    logic [15:0] tx_ack;
    logic [31:0] tx_length;
    logic [31:0] tx_frame_count;
    logic [15:0] tx_checksum;
  } saw_result_t;

endpackage

FILE: hdl/saw_item_if.sv
// Input channel carrying one command item with its frame header fields.
interface saw_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] flags;
  logic [15:0] seq_number;
  logic [15:0] ack_number;
  logic [31:0] payload_length;
  logic [31:0] frame_count;
  logic [15:0] checksum_in;

  modport source (
    output valid, command, flags, seq_number, ack_number, payload_length,
           frame_count, checksum_in,
    input  ready
  );

  modport sink (
    input  valid, command, flags, seq_number, ack_number, payload_length,
           frame_count, checksum_in,
    output ready
  );
endinterface

FILE: hdl/saw_result_if.sv
// Output channel carrying one status result with the emitted header.
interface saw_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        tx_valid;
  logic [31:0] tx_flags;
  logic [15:0] tx_seq;
  logic [15:0] tx_ack;
  logic [31:0] tx_length;
  logic [31:0] tx_frame_count;
  logic [15:0] tx_checksum;

  modport source (
    output valid, status, tx_valid, tx_flags, tx_seq, tx_ack, tx_length,
           tx_frame_count, tx_checksum,
    input  ready
  );

  modport sink (
    input  valid, status, tx_valid, tx_flags, tx_seq, tx_ack, tx_length,
           tx_frame_count, tx_checksum,
    output ready
  );
endinterface

FILE: hdl/saw_csum.sv
// One's-complement sum over the eight big-endian words of a 16-byte header.
module saw_csum (
  input  logic [31:0]              flags_i,
  input  logic [15:0]              seq_i,
  input  logic [15:0]              ack_i,
  input  logic [31:0]              length_i,
  input  logic [31:0]              count_i,
  output logic [saw_pkg::WordW-1:0] sum_o
);
  import saw_pkg::*;

  logic [WordW-1:0] words [8];
  logic [WordW+2:0] total;
  logic [WordW:0]   fold1;

  // Byte-swap each little-endian half into a big-endian word
  always_comb begin
    words[0] = {flags_i[7:0],   flags_i[15:8]};
    words[1] = {flags_i[23:16], flags_i[31:24]};
    words[2] = {seq_i[7:0],     seq_i[15:8]};
    words[3] = {ack_i[7:0],     ack_i[15:8]};
    words[4] = {length_i[7:0],  length_i[15:8]};
    words[5] = {length_i[23:16], length_i[31:24]};
    words[6] = {count_i[7:0],   count_i[15:8]};
    words[7] = {count_i[23:16], count_i[31:24]};
  end

  // Add all words, then fold the carries back in twice (end-around carry)
  always_comb begin
    total = '0;
    for (int i = 0; i < 8; i++) begin
      total = total + {3'b000, words[i]};
    end
    fold1 = {1'b0, total[WordW-1:0]} + {{(WordW-2){1'b0}}, total[WordW+2:WordW]};
    sum_o = fold1[WordW-1:0] + {{(WordW-1){1'b0}}, fold1[WordW]};
  end

endmodule

FILE: hdl/stop_and_wait_arq_sender.sv
// Stop-and-wait sender: latches a frame header, checksums it, emits it and
// retransmits on timeout until an acknowledgment arrives or retries run out.
// Each command item (send, tick or received frame) gives exactly one result
// item, registered in the cycle after the item is taken, and a new item is
// taken in every cycle as long as the result register is empty or being
// drained in that same cycle; the whole decision, including the eight-word
// header checksum, is one pass of logic from the input port into the result
// register. Ticks count towards timeout_ticks; on the max_retries-th timeout
// the sender reports that it gave up and goes idle. Configuration writes take
// effect on the next item and should only be made while no result is pending.
module stop_and_wait_arq_sender (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  saw_item_if.sink            item_i,
  saw_result_if.source        result_o
);
  import saw_pkg::*;

  // Configuration registers
  logic [15:0] timeout_ticks_q;
  logic [3:0]  max_retries_q;

  // Sender state
  logic        busy_q, busy_d;
  logic [15:0] wait_ticks_q, wait_ticks_d;
  logic [3:0]  retry_count_q, retry_count_d;
  logic [31:0] held_flags_q;
  logic [15:0] held_seq_q;
  logic [15:0] held_ack_q;
  logic [31:0] held_length_q;
  logic [31:0] held_count_q;
  logic [15:0] held_checksum_q;
  logic        load_held;

  // Result register
  logic        res_valid_q, res_valid_d;
  saw_result_t res_q, res_d;

  logic        accept;
  logic [31:0] csum_flags;
  logic [15:0] hdr_sum;
  logic [16:0] verify_sum;
  logic [15:0] wait_inc;
  logic [3:0]  retry_inc;
  logic        ack_ok;
  saw_cmd_e    cmd;

  assign cmd = saw_cmd_e'(item_i.command);

  // Take a new item whenever the result register is free or being drained
  assign item_i.ready = !res_valid_q || result_o.ready;
  assign accept       = item_i.valid && item_i.ready;

  // A send checksums the header with EXT forced on; a received frame as is
  always_comb begin
    csum_flags = item_i.flags;
    if (cmd == CMD_SEND) begin
      csum_flags[FlagExtBit] = 1'b1;
    end
  end

  saw_csum u_csum (
    .flags_i  (csum_flags),
    .seq_i    (item_i.seq_number),
    .ack_i    (item_i.ack_number),
    .length_i (item_i.payload_length),
    .count_i  (item_i.frame_count),
    .sum_o    (hdr_sum)
  );

  assign verify_sum = {1'b0, item_i.checksum_in} + {1'b0, hdr_sum};
  assign wait_inc   = (wait_ticks_q == WordOnes) ? wait_ticks_q : wait_ticks_q + 16'd1;
  assign retry_inc  = retry_count_q + 4'd1;
  assign ack_ok     = busy_q && item_i.flags[FlagExtBit] && item_i.flags[FlagAckBit]
                      && (verify_sum == {1'b0, WordOnes})
                      && (item_i.ack_number == held_seq_q);

  // Decide the result and the next state for the offered item
  always_comb begin
    busy_d        = busy_q;
    wait_ticks_d  = wait_ticks_q;
    retry_count_d = retry_count_q;
    load_held     = 1'b0;
    res_d         = '0;
    res_d.status  = ST_NONE;
    case (cmd)
      CMD_SEND: begin
        if (busy_q) begin
          res_d.status = ST_REJECTED;
        end else begin
          load_held            = 1'b1;
          busy_d               = 1'b1;
          wait_ticks_d         = '0;
          retry_count_d        = '0;
          res_d.status         = ST_SENT;
          res_d.tx_valid       = 1'b1;
          res_d.tx_flags       = csum_flags;
          res_d.tx_seq         = item_i.seq_number;
          res_d.tx_ack         = item_i.ack_number;
          res_d.tx_length      = item_i.payload_length;
          res_d.tx_frame_count = item_i.frame_count;
          res_d.tx_checksum    = ~hdr_sum;
        end
      end
      CMD_TICK: begin
        if (busy_q) begin
          wait_ticks_d = wait_inc;
          if (wait_inc >= timeout_ticks_q) begin
            wait_ticks_d         = '0;
            retry_count_d        = retry_inc;
            res_d.tx_valid       = 1'b1;
            res_d.tx_flags       = held_flags_q;
            res_d.tx_seq         = held_seq_q;
            res_d.tx_ack         = held_ack_q;
            res_d.tx_length      = held_length_q;
            res_d.tx_frame_count = held_count_q;
            res_d.tx_checksum    = held_checksum_q;
            if (retry_inc >= max_retries_q) begin
              busy_d       = 1'b0;
              res_d.status = ST_GAVE_UP;
            end else begin
              res_d.status = ST_RETRANSMIT;
            end
          end
        end
      end
      CMD_RECV: begin
        if (ack_ok) begin
          busy_d       = 1'b0;
          wait_ticks_d = '0;
          res_d.status = ST_ACKED;
        end else begin
          res_d.status = ST_IGNORED;
        end
      end
      default: begin
        res_d.status = ST_NONE;
      end
    endcase
  end

  // Set the result valid on a transfer in, drop it once taken
  always_comb begin
    res_valid_d = res_valid_q;
    if (accept) begin
      res_valid_d = 1'b1;
    end else if (result_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_ticks_q <= TimeoutTicksRst;
      max_retries_q   <= MaxRetriesRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTimeoutTicks: timeout_ticks_q <= cfg_data_i;
        CfgMaxRetries:   max_retries_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Control state: advance on each transfer in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      wait_ticks_q  <= '0;
      retry_count_q <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (accept) begin
        busy_q        <= busy_d;
        wait_ticks_q  <= wait_ticks_d;
        retry_count_q <= retry_count_d;
      end
    end
  end

  // Held frame and result payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q           <= '0;
      held_flags_q    <= '0;
      held_seq_q      <= '0;
      held_ack_q      <= '0;
      held_length_q   <= '0;
      held_count_q    <= '0;
      held_checksum_q <= '0;
    end else if (accept) begin
      res_q <= res_d;
      if (load_held) begin
        held_flags_q    <= csum_flags;
        held_seq_q      <= item_i.seq_number;
        held_ack_q      <= item_i.ack_number;
        held_length_q   <= item_i.payload_length;
        held_count_q    <= item_i.frame_count;
        held_checksum_q <= ~hdr_sum;
      end
    end
  end

  // Drive the result channel
  assign result_o.valid          = res_valid_q;
  assign result_o.status         = res_q.status;
  assign result_o.tx_valid       = res_q.tx_valid;
  assign result_o.tx_flags       = res_q.tx_flags;
  assign result_o.tx_seq         = res_q.tx_seq;
  assign result_o.tx_ack         = res_q.tx_ack;
  assign result_o.tx_length      = res_q.tx_length;
  assign result_o.tx_frame_count = res_q.tx_frame_count;
  assign result_o.tx_checksum    = res_q.tx_checksum;

endmodule

FILE: dv/saw_frame_checker.sv
// Header checksum helper and the transfer checker for the stop-and-wait frame sender.
package saw_hdr_pkg;
  import saw_pkg::*;

  // One command item as offered on the input channel
  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] flags;
    logic [15:0] seq;
    logic [15:0] ack;
    logic [31:0] length;
    logic [31:0] count;
    logic [15:0] csum;
  } frame_item_t;

  // Sum the 16-byte little-endian header image as eight big-endian words,
  // wrapping every carry back into the low end
  function automatic logic [15:0] header_ones_sum(input logic [31:0] fl,
                                                  input logic [15:0] sq,
                                                  input logic [15:0] ak,
                                                  input logic [31:0] ln,
                                                  input logic [31:0] ct);
    logic [15:0] words [8];
    logic [16:0] acc;
    words[0] = {fl[7:0], fl[15:8]};
    words[1] = {fl[23:16], fl[31:24]};
    words[2] = {sq[7:0], sq[15:8]};
    words[3] = {ak[7:0], ak[15:8]};
    words[4] = {ln[7:0], ln[15:8]};
    words[5] = {ln[23:16], ln[31:24]};
    words[6] = {ct[7:0], ct[15:8]};
    words[7] = {ct[23:16], ct[31:24]};
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      acc = {1'b0, acc[15:0]} + {1'b0, words[i]};
      if (acc[16]) begin
        acc = {1'b0, acc[15:0]} + 17'd1;
      end
    end
    return acc[15:0];
  endfunction

endpackage

module saw_frame_checker
  import saw_pkg::*;
  import saw_hdr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  saw_item_if         item_mon,
  saw_result_if       result_mon,
  output int          fail_count_o,
  output int          pending_o,
  output logic [15:0] held_seq_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Sender model: limits, held frame and wait state
  logic [15:0] timeout_cfg;
  logic [3:0]  retry_limit;
  logic        busy;
  logic [31:0] hold_flags;
  logic [15:0] hold_seq;
  logic [15:0] hold_ack;
  logic [31:0] hold_len;
  logic [31:0] hold_cnt;
  logic [15:0] hold_csum;
  logic [15:0] tick_cnt;
  logic [3:0]  retries_done;

  saw_result_t results_due [$];

  assign held_seq_o = hold_seq;

  function automatic saw_result_t held_frame(input saw_status_e st);
    saw_result_t r;
    r.status         = st;
    r.tx_valid       = 1'b1;
    r.tx_flags       = hold_flags;
    r.tx_seq         = hold_seq;
    r.tx_ack         = hold_ack;
    r.tx_length      = hold_len;
    r.tx_frame_count = hold_cnt;
    r.tx_checksum    = hold_csum;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    saw_result_t want;
    logic        hdr_ok;
    if (!rst_ni) begin
      timeout_cfg  = TimeoutTicksRst;
      retry_limit  = MaxRetriesRst;
      busy         = 1'b0;
      hold_flags   = '0;
      hold_seq     = '0;
      hold_ack     = '0;
      hold_len     = '0;
      hold_cnt     = '0;
      hold_csum    = '0;
      tick_cnt     = '0;
      retries_done = '0;
      results_due.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      // Match each result transfer against the oldest prediction
      if (result_mon.valid && result_mon.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result expected none, got status %0d", $time,
                   result_mon.status);
          fail_count_o++;
        end else begin
          want = results_due.pop_front();
          compare_field("status", want.status, result_mon.status);
          compare_field("tx_valid", want.tx_valid, result_mon.tx_valid);
          compare_field("tx_flags", want.tx_flags, result_mon.tx_flags);
          compare_field("tx_seq", want.tx_seq, result_mon.tx_seq);
          compare_field("tx_ack", want.tx_ack, result_mon.tx_ack);
          compare_field("tx_length", want.tx_length, result_mon.tx_length);
          compare_field("tx_frame_count", want.tx_frame_count,
                        result_mon.tx_frame_count);
          compare_field("tx_checksum", want.tx_checksum, result_mon.tx_checksum);
        end
      end

      // Advance the model on each item transfer and queue what it emits
      if (item_mon.valid && item_mon.ready) begin
        want = '0;
        want.status = ST_NONE;
        case (item_mon.command)
          CMD_SEND: begin
            if (busy) begin
              want.status = ST_REJECTED;
            end else begin
              hold_flags   = item_mon.flags | (32'd1 << FlagExtBit);
              hold_seq     = item_mon.seq_number;
              hold_ack     = item_mon.ack_number;
              hold_len     = item_mon.payload_length;
              hold_cnt     = item_mon.frame_count;
              hold_csum    = ~header_ones_sum(hold_flags, hold_seq, hold_ack,
                                              hold_len, hold_cnt);
              busy         = 1'b1;
              tick_cnt     = '0;
              retries_done = '0;
              want         = held_frame(ST_SENT);
            end
          end
          CMD_TICK: begin
            if (busy) begin
              if (tick_cnt != WordOnes) begin
                tick_cnt++;
              end
              if (tick_cnt >= timeout_cfg) begin
                tick_cnt     = '0;
                retries_done = retries_done + 4'd1;
                if (retries_done >= retry_limit) begin
                  busy = 1'b0;
                  want = held_frame(ST_GAVE_UP);
                end else begin
                  want = held_frame(ST_RETRANSMIT);
                end
              end
            end
          end
          CMD_RECV: begin
            hdr_ok = busy && item_mon.flags[FlagExtBit] && item_mon.flags[FlagAckBit]
              && ({1'b0, item_mon.checksum_in}
                  + {1'b0, header_ones_sum(item_mon.flags, item_mon.seq_number,
                                           item_mon.ack_number,
                                           item_mon.payload_length,
                                           item_mon.frame_count)}
                  == {1'b0, WordOnes})
              && (item_mon.ack_number == hold_seq);
            if (hdr_ok) begin
              busy        = 1'b0;
              tick_cnt    = '0;
              want.status = ST_ACKED;
            end else begin
              want.status = ST_IGNORED;
            end
          end
          default: ;
        endcase
        results_due.push_back(want);
      end

      // Track register writes
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgTimeoutTicks) begin
          timeout_cfg = cfg_data_i;
        end else begin
          retry_limit = cfg_data_i[3:0];
        end
      end

      pending_o = results_due.size();
    end
  end

endmodule

FILE: dv/stop_and_wait_arq_sender_tb.sv
// Stimulus, clock, reset and verdict for the stop-and-wait frame sender.
module stop_and_wait_arq_sender_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import saw_pkg::*;
  import saw_hdr_pkg::*;

  localparam int ClkPeriod   = 8;
  localparam int RandomItems = 1600;
  localparam int PhaseCnt    = 7;
  localparam int TickCap     = 48;
  localparam int HoldCycles  = 64;
  localparam int HoldAfter   = 300;
  localparam int TailCycles  = 8;

  localparam logic [1:0] CmdUnused = 2'd3;

  // Limits per random phase; the last phase draws its own
  localparam logic [15:0] TimeoutPlan [PhaseCnt] = '{16'd1, 16'd0, 16'd3, 16'd2,
                                                     16'd7, 16'd65535, 16'd5};
  localparam logic [3:0]  RetryPlan   [PhaseCnt] = '{4'd1, 4'd0, 4'd4, 4'd15,
                                                     4'd10, 4'd15, 4'd3};

  typedef enum int {
    ACK_GOOD,
    ACK_BAD_SUM,
    ACK_NO_EXT,
    ACK_NO_ACK,
    ACK_WRONG_SEQ
  } ack_form_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;

  int          fail_count;
  int          pending;
  logic [15:0] held_seq;

  int          idle_mode;
  bit          hold_off_req;
  int          counted;

  saw_item_if   item_ch ();
  saw_result_if result_ch ();

  stop_and_wait_arq_sender dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_ch),
    .result_o   (result_ch)
  );

  saw_frame_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_mon     (item_ch),
    .result_mon   (result_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .held_seq_o   (held_seq)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  initial begin
    #4ms;
    $display("stop_and_wait_arq_sender: mismatch");
    $finish;
  end

  function automatic frame_item_t random_frame(input logic [1:0] cmd);
    frame_item_t it;
    it.command = cmd;
    it.flags   = $urandom;
    it.seq     = 16'($urandom);
    it.ack     = 16'($urandom);
    it.length  = $urandom;
    it.count   = $urandom;
    it.csum    = 16'($urandom);
    return it;
  endfunction

  // Offer one item after a random gap and hold it until the transfer
  task automatic offer(input frame_item_t it);
    int gap_pct;
    gap_pct = (idle_mode == 0) ? 12 : (idle_mode == 1) ? 86 : 0;
    while ($urandom_range(99) < gap_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_ch.valid          <= 1'b1;
    item_ch.command        <= it.command;
    item_ch.flags          <= it.flags;
    item_ch.seq_number     <= it.seq;
    item_ch.ack_number     <= it.ack;
    item_ch.payload_length <= it.length;
    item_ch.frame_count    <= it.count;
    item_ch.checksum_in    <= it.csum;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Build a received frame aimed at the held sequence number, well formed
  // or broken in exactly one way
  task automatic offer_ack(input logic [15:0] target, input ack_form_e form);
    frame_item_t it;
    it = random_frame(CMD_RECV);
    it.flags[FlagAckBit] = 1'b1;
    it.flags[FlagExtBit] = 1'b1;
    it.ack = target;
    case (form)
      ACK_NO_EXT:    it.flags[FlagExtBit] = 1'b0;
      ACK_NO_ACK:    it.flags[FlagAckBit] = 1'b0;
      ACK_WRONG_SEQ: it.ack = target ^ 16'($urandom_range(1, 65535));
      default: ;
    endcase
    it.csum = ~header_ones_sum(it.flags, it.seq, it.ack, it.length, it.count);
    if (form == ACK_BAD_SUM) begin
      it.csum = it.csum ^ 16'($urandom_range(1, 65535));
    end
    offer(it);
  endtask

  // Stop offering and wait until every result is back
  task automatic settle();
    item_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  task automatic program_limits(input logic [15:0] tmo, input logic [3:0] lim);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgTimeoutTicks;
    cfg_data_i <= tmo;
    @(negedge clk_i);
    cfg_idx_i  <= CfgMaxRetries;
    cfg_data_i <= {12'd0, lim};
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    bit hold_served;
    int gap_pct;
    hold_served = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_served) begin
        hold_served = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else begin
        gap_pct = (idle_mode == 0) ? 86 : (idle_mode == 1) ? 12 : 0;
        result_ch.ready <= ($urandom_range(99) >= gap_pct);
      end
    end
  end

  initial begin
    frame_item_t it;
    logic [15:0] tmo;
    logic [3:0]  lim;
    int          span;
    int          ticks;

    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = CfgTimeoutTicks;
    cfg_data_i             = '0;
    item_ch.valid          = 1'b0;
    item_ch.command        = CMD_SEND;
    item_ch.flags          = '0;
    item_ch.seq_number     = '0;
    item_ch.ack_number     = '0;
    item_ch.payload_length = '0;
    item_ch.frame_count    = '0;
    item_ch.checksum_in    = '0;
    result_ch.ready        = 1'b0;
    idle_mode              = 0;
    hold_off_req           = 1'b0;
    counted                = 0;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: idle corner cases at the reset limits
    it = random_frame(CMD_TICK);
    offer(it);
    offer_ack(16'h0000, ACK_GOOD);
    it = random_frame(CmdUnused);
    offer(it);

    // All-ones header, then a send while busy, each broken acknowledgment, a tick and a good acknowledgment
    it = '1;
    it.command = CMD_SEND;
    offer(it);
    it = '0;
    it.command = CMD_SEND;
    offer(it);
    offer_ack(16'hFFFF, ACK_BAD_SUM);
    offer_ack(16'hFFFF, ACK_NO_EXT);
    offer_ack(16'hFFFF, ACK_NO_ACK);
    offer_ack(16'hFFFF, ACK_WRONG_SEQ);
    it = random_frame(CMD_TICK);
    offer(it);
    offer_ack(16'hFFFF, ACK_GOOD);

    // All-zero header, acknowledged by an all-zero-content frame
    it = '0;
    it.command = CMD_SEND;
    offer(it);
    it = '0;
    it.command = CMD_RECV;
    it.flags[FlagAckBit] = 1'b1;
    it.flags[FlagExtBit] = 1'b1;
    it.csum = ~header_ones_sum(it.flags, it.seq, it.ack, it.length, it.count);
    offer(it);

    // Zero limits: give up on the very first tick
    settle();
    program_limits(16'd0, 4'd0);
    offer(random_frame(CMD_SEND));
    offer(random_frame(CMD_TICK));
    offer(random_frame(CMD_TICK));

    // One retransmission, then give up
    settle();
    program_limits(16'd1, 4'd2);
    offer(random_frame(CMD_SEND));
    offer(random_frame(CMD_TICK));
    offer(random_frame(CMD_TICK));
    offer(random_frame(CMD_TICK));

    // Random phases: mostly send / tick / acknowledge exchanges
    for (int ph = 0; ph < PhaseCnt; ph++) begin
      tmo = TimeoutPlan[ph];
      lim = RetryPlan[ph];
      if (ph == PhaseCnt - 1) begin
        tmo = 16'($urandom_range(1, 12));
        lim = 4'($urandom_range(1, 15));
      end
      settle();
      program_limits(tmo, lim);
      span = ((tmo == 0) ? 1 : int'(tmo)) * ((lim == 0) ? 1 : int'(lim)) + 1;
      if (span > TickCap) begin
        span = TickCap;
      end
      while (counted < (ph + 1) * RandomItems / PhaseCnt) begin
        idle_mode = counted * 3 / RandomItems;
        if (idle_mode > 2) begin
          idle_mode = 2;
        end
        if ($urandom_range(9) == 0) begin
          // Noise: any command with any content
          offer(random_frame(2'($urandom_range(3))));
        end else begin
          offer(random_frame(CMD_SEND));
          counted++;
          if ($urandom_range(6) == 0) begin
            offer(random_frame(CMD_SEND));
            counted++;
          end
          ticks = $urandom_range(0, span);
          // Once, keep ticks flowing while the receiver holds off
          if (!hold_off_req && counted >= HoldAfter) begin
            hold_off_req = 1'b1;
            ticks = TickCap;
          end
          repeat (ticks) begin
            offer(random_frame(CMD_TICK));
            counted++;
            if ($urandom_range(15) == 0) begin
              offer_ack(held_seq, ack_form_e'($urandom_range(1, 4)));
            end
          end
          settle();
          if ($urandom_range(4) == 0) begin
            offer_ack(held_seq, ack_form_e'($urandom_range(1, 4)));
          end else begin
            offer_ack(held_seq, ACK_GOOD);
            counted++;
          end
        end
      end
    end

    // Drain, allow the pipeline to go quiet, then give the verdict
    settle();
    repeat (TailCycles) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("stop_and_wait_arq_sender: match");
    end else begin
      $display("stop_and_wait_arq_sender: mismatch");
    end
    $finish;
  end

endmodule
